/* rtl/assert_macros.svh */
// Assertion macros used by the top level of the moving interquartile mean block.
// Every macro samples on clk_i and is disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds at every clock edge.
`define ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Check that a consequent holds in the same cycle as its antecedent.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

/* rtl/miqm_pkg.sv */
// Package of the moving interquartile mean block: widths, codes, types.
// Depends on nothing; used by every other RTL file but miqm_div.
`default_nettype none

package miqm_pkg;

  localparam int unsigned MIQM_WINDOW = 16;
  localparam int unsigned SAMPLE_W    = 32;
  localparam int unsigned MEAN_W      = 40;
  localparam int unsigned COUNT_W     = 5;

  // Command codes carried with each input item
  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_CLEAR  = 1'b1
  } miqm_cmd_e;

  // Sequencer states of the window core
  typedef enum logic [2:0] {
    CS_IDLE,
    CS_RING,
    CS_REMOVE,
    CS_INSERT,
    CS_INS_LAST,
    CS_SUM,
    CS_DONE
  } miqm_core_state_e;

  // Request from the top level to the window core
  typedef struct packed {
    logic                start;
    logic                clear;
    logic [SAMPLE_W-1:0] sample;
  } miqm_req_t;

  // Status from the window core
  typedef struct packed {
    logic done;
    logic clear;
  } miqm_sts_t;

endpackage

`default_nettype wire

/* rtl/miqm_if.sv */
// Handshake channels of the moving interquartile mean block.
// Depends on miqm_pkg for the payload widths.
`default_nettype none

interface miqm_in_if;
  import miqm_pkg::*;
  logic                       valid;
  logic                       ready;
  logic                       command;
  logic signed [SAMPLE_W-1:0] sample_value;

  modport source (output valid, output command, output sample_value, input ready);
  modport sink   (input valid, input command, input sample_value, output ready);
endinterface

interface miqm_out_if;
  import miqm_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [MEAN_W-1:0] mean_value;
  logic [COUNT_W-1:0]       held_count;

  modport source (output valid, output mean_value, output held_count, input ready);
  modport sink   (input valid, input mean_value, input held_count, output ready);
endinterface

`default_nettype wire

/* rtl/miqm_div.sv */
// Serial signed divider: one quotient bit per cycle, truncates toward zero.
// Depends on nothing but its parameters.
`default_nettype none

module miqm_div #(
  parameter int unsigned NUM_W = 48,
  parameter int unsigned DEN_W = 5
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0]        den_i,
  output logic                    done_o,
  output logic signed [NUM_W-1:0] quo_o
);

  localparam int unsigned STEP_W = $clog2(NUM_W + 1);

  logic              run_q, run_d;
  logic              done_q, done_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [NUM_W-1:0]  mag_q, mag_d;
  logic [DEN_W-1:0]  rem_q, rem_d;
  logic [DEN_W-1:0]  den_q, den_d;
  logic              neg_q, neg_d;
  logic [DEN_W:0]    rem_sh;

  // One restoring step per cycle
  always_comb begin
    run_d  = run_q;
    done_d = 1'b0;
    step_d = step_q;
    mag_d  = mag_q;
    rem_d  = rem_q;
    den_d  = den_q;
    neg_d  = neg_q;
    rem_sh = {rem_q, mag_q[NUM_W-1]};
    if (start_i) begin
      run_d  = 1'b1;
      step_d = '0;
      rem_d  = '0;
      den_d  = den_i;
      neg_d  = num_i[NUM_W-1];
      mag_d  = num_i[NUM_W-1] ? NUM_W'(-num_i) : NUM_W'(num_i);
    end else if (run_q) begin
      if (rem_sh >= {1'b0, den_q}) begin
        rem_d = DEN_W'(rem_sh - {1'b0, den_q});
        mag_d = {mag_q[NUM_W-2:0], 1'b1};
      end else begin
        rem_d = rem_sh[DEN_W-1:0];
        mag_d = {mag_q[NUM_W-2:0], 1'b0};
      end
      step_d = step_q + 1'b1;
      if (step_q == STEP_W'(NUM_W - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    step_q <= step_d;
    mag_q  <= mag_d;
    rem_q  <= rem_d;
    den_q  <= den_d;
    neg_q  <= neg_d;
  end

  assign done_o = done_q;
  assign quo_o  = neg_q ? -$signed(mag_q) : $signed(mag_q);

endmodule

`default_nettype wire

/* rtl/miqm_core.sv */
// Window core: arrival ring and sorted copy in two memories, with the
// sequencer for remove, insert and weighted sum. Depends on miqm_pkg.
`default_nettype none

module miqm_core #(
  parameter int unsigned WINDOW = miqm_pkg::MIQM_WINDOW,
  parameter int unsigned CNT_W  = $clog2(WINDOW + 1),
  parameter int unsigned NUM_W  = miqm_pkg::SAMPLE_W + CNT_W + 11
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  miqm_pkg::miqm_req_t     req_i,
  output miqm_pkg::miqm_sts_t     sts_o,
  output logic signed [NUM_W-1:0] num_o,
  output logic [CNT_W-1:0]        count_o
);

  import miqm_pkg::*;

  localparam int unsigned PTR_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned ACC_W = SAMPLE_W + CNT_W + 2;

  logic [SAMPLE_W-1:0] sort_mem [WINDOW];
  logic [SAMPLE_W-1:0] ring_mem [WINDOW];

  miqm_core_state_e state_q, state_d;
  logic [CNT_W-1:0]           cnt_q, cnt_d;
  logic [PTR_W-1:0]           oldest_q, oldest_d;
  logic signed [SAMPLE_W-1:0] samp_q, samp_d;
  logic signed [SAMPLE_W-1:0] oldv_q, oldv_d;
  logic [CNT_W-1:0]           k_q, k_d;
  logic                       more_q, more_d;
  logic                       pend_q, pend_d;
  logic [CNT_W-1:0]           dk_q, dk_d;
  logic                       found_q, found_d;
  logic [CNT_W-1:0]           m_q, m_d;
  logic signed [ACC_W-1:0]    acc_q, acc_d;
  logic [CNT_W-1:0]           lo_q, lo_d;
  logic [CNT_W-1:0]           hi_q, hi_d;
  logic [2:0]                 ew_q, ew_d;
  logic [2:0]                 iw_q, iw_d;
  logic [3:0]                 sh_q, sh_d;
  logic                       clr_q, clr_d;

  // Memory ports
  logic                       srt_re, srt_we;
  logic [PTR_W-1:0]           srt_ra, srt_wa;
  logic [SAMPLE_W-1:0]        srt_wd;
  logic signed [SAMPLE_W-1:0] srt_rd_q;
  logic                       ring_re, ring_we;
  logic [PTR_W-1:0]           ring_wa;
  logic [SAMPLE_W-1:0]        ring_wd;
  logic signed [SAMPLE_W-1:0] ring_rd_q;

  logic                       full;
  logic [CNT_W:0]             widx;
  logic [CNT_W+1:0]           nx_e;
  logic [CNT_W-1:0]           nx, nq;
  logic                       nsmall;
  logic                       go_sum;
  logic [2:0]                 wsel;
  logic signed [SAMPLE_W+3:0] prod;

  assign full = (cnt_q == CNT_W'(WINDOW));

  // Ring slot of the next sample while the window is not full
  always_comb begin
    widx = (CNT_W+1)'(oldest_q) + (CNT_W+1)'(cnt_q);
    if (widx >= (CNT_W+1)'(WINDOW)) begin
      widx = widx - (CNT_W+1)'(WINDOW);
    end
  end

  // Sum bounds and weights for the new count
  always_comb begin
    nx     = m_q + 1'b1;
    nx_e   = (CNT_W+2)'(nx);
    nq     = CNT_W'(nx_e >> 2);
    nsmall = (nx_e <= (CNT_W+2)'(4));
  end

  assign go_sum = ((state_q == CS_INSERT) && pend_q && (srt_rd_q < samp_q))
               || (state_q == CS_INS_LAST);

  assign wsel = ((dk_q == lo_q) || (dk_q == hi_q)) ? ew_q : iw_q;
  assign prod = srt_rd_q * $signed({1'b0, wsel});

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      CS_IDLE: begin
        if (req_i.start) begin
          if (req_i.clear) begin
            state_d = CS_DONE;
          end else if (full) begin
            state_d = CS_RING;
          end else if (cnt_q == '0) begin
            state_d = CS_INS_LAST;
          end else begin
            state_d = CS_INSERT;
          end
        end
      end
      CS_RING: state_d = CS_REMOVE;
      CS_REMOVE: begin
        if (pend_q && (dk_q == CNT_W'(WINDOW - 1))) begin
          state_d = (WINDOW == 1) ? CS_INS_LAST : CS_INSERT;
        end
      end
      CS_INSERT: begin
        if (pend_q) begin
          if (srt_rd_q >= samp_q) begin
            if (dk_q == '0) begin
              state_d = CS_INS_LAST;
            end
          end else begin
            state_d = CS_SUM;
          end
        end
      end
      CS_INS_LAST: state_d = CS_SUM;
      CS_SUM: begin
        if (pend_q && (dk_q == hi_q)) begin
          state_d = CS_DONE;
        end
      end
      CS_DONE: state_d = CS_IDLE;
      default: state_d = CS_IDLE;
    endcase
  end

  // Memory controls and datapath
  always_comb begin
    cnt_d    = cnt_q;
    oldest_d = oldest_q;
    samp_d   = samp_q;
    oldv_d   = oldv_q;
    k_d      = k_q;
    more_d   = more_q;
    pend_d   = pend_q;
    dk_d     = dk_q;
    found_d  = found_q;
    m_d      = m_q;
    acc_d    = acc_q;
    lo_d     = lo_q;
    hi_d     = hi_q;
    ew_d     = ew_q;
    iw_d     = iw_q;
    sh_d     = sh_q;
    clr_d    = clr_q;
    srt_re   = 1'b0;
    srt_ra   = k_q[PTR_W-1:0];
    srt_we   = 1'b0;
    srt_wa   = '0;
    srt_wd   = samp_q;
    ring_re  = 1'b0;
    ring_we  = 1'b0;
    ring_wa  = oldest_q;
    ring_wd  = samp_q;

    case (state_q)
      CS_IDLE: begin
        if (req_i.start) begin
          samp_d = $signed(req_i.sample);
          clr_d  = req_i.clear;
          if (req_i.clear) begin
            cnt_d    = '0;
            oldest_d = '0;
          end else if (full) begin
            ring_re = 1'b1;
          end else begin
            ring_we = 1'b1;
            ring_wa = widx[PTR_W-1:0];
            ring_wd = req_i.sample;
            m_d     = cnt_q;
            k_d     = cnt_q - 1'b1;
            more_d  = 1'b1;
            pend_d  = 1'b0;
          end
        end
      end
      CS_RING: begin
        // Overwrite the oldest slot and start scanning for its sorted copy
        oldv_d   = ring_rd_q;
        ring_we  = 1'b1;
        oldest_d = (oldest_q == PTR_W'(WINDOW - 1)) ? '0 : oldest_q + 1'b1;
        k_d      = '0;
        more_d   = 1'b1;
        pend_d   = 1'b0;
        found_d  = 1'b0;
      end
      CS_REMOVE: begin
        if (more_q) begin
          srt_re = 1'b1;
          k_d    = k_q + 1'b1;
          more_d = (k_q != CNT_W'(WINDOW - 1));
        end
        pend_d = more_q;
        dk_d   = k_q;
        // Close the gap behind the first matching entry
        if (pend_q) begin
          if (found_q) begin
            srt_we = 1'b1;
            srt_wa = PTR_W'(dk_q - 1'b1);
            srt_wd = srt_rd_q;
          end else if (srt_rd_q >= oldv_q) begin
            found_d = 1'b1;
          end
          if (dk_q == CNT_W'(WINDOW - 1)) begin
            m_d    = CNT_W'(WINDOW - 1);
            k_d    = CNT_W'(WINDOW - 1) - 1'b1;
            more_d = 1'b1;
            pend_d = 1'b0;
          end
        end
      end
      CS_INSERT: begin
        if (more_q) begin
          srt_re = 1'b1;
          k_d    = k_q - 1'b1;
          more_d = (k_q != '0);
        end
        pend_d = more_q;
        dk_d   = k_q;
        // Shift entries not below the sample up by one, then drop it in
        if (pend_q) begin
          srt_we = 1'b1;
          srt_wa = PTR_W'(dk_q + 1'b1);
          srt_wd = (srt_rd_q >= samp_q) ? srt_rd_q : samp_q;
        end
      end
      CS_INS_LAST: begin
        srt_we = 1'b1;
        srt_wa = '0;
        srt_wd = samp_q;
      end
      CS_SUM: begin
        if (more_q) begin
          srt_re = 1'b1;
          k_d    = k_q + 1'b1;
          more_d = (k_q != hi_q);
        end
        pend_d = more_q;
        dk_d   = k_q;
        if (pend_q) begin
          acc_d = acc_q + ACC_W'(prod);
        end
      end
      CS_DONE: begin
      end
      default: begin
      end
    endcase

    // Set up the weighted sum over the new window
    if (go_sum) begin
      cnt_d  = nx;
      lo_d   = nsmall ? '0 : nq;
      hi_d   = nsmall ? nx - 1'b1 : nx - 1'b1 - nq;
      ew_d   = (nsmall || (nx_e[1:0] == 2'd0)) ? 3'd1 : 3'd4 - {1'b0, nx_e[1:0]};
      iw_d   = (nsmall || (nx_e[1:0] == 2'd0)) ? 3'd1 : 3'd4;
      sh_d   = nsmall ? 4'd8 : ((nx_e[1:0] == 2'd0) ? 4'd9 : 4'd7);
      k_d    = nsmall ? '0 : nq;
      more_d = 1'b1;
      pend_d = 1'b0;
      acc_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= CS_IDLE;
      cnt_q    <= '0;
      oldest_q <= '0;
      more_q   <= 1'b0;
      pend_q   <= 1'b0;
      found_q  <= 1'b0;
      clr_q    <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      oldest_q <= oldest_d;
      more_q   <= more_d;
      pend_q   <= pend_d;
      found_q  <= found_d;
      clr_q    <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    samp_q <= samp_d;
    oldv_q <= oldv_d;
    k_q    <= k_d;
    dk_q   <= dk_d;
    m_q    <= m_d;
    acc_q  <= acc_d;
    lo_q   <= lo_d;
    hi_q   <= hi_d;
    ew_q   <= ew_d;
    iw_q   <= iw_d;
    sh_q   <= sh_d;
  end

  // Sorted copy memory
  always_ff @(posedge clk_i) begin
    if (srt_we) begin
      sort_mem[srt_wa] <= srt_wd;
    end
    if (srt_re) begin
      srt_rd_q <= sort_mem[srt_ra];
    end
  end

  // Arrival ring memory
  always_ff @(posedge clk_i) begin
    if (ring_we) begin
      ring_mem[ring_wa] <= ring_wd;
    end
    if (ring_re) begin
      ring_rd_q <= ring_mem[oldest_q];
    end
  end

  assign sts_o.done  = (state_q == CS_DONE);
  assign sts_o.clear = clr_q;
  assign num_o       = NUM_W'(acc_q) <<< sh_q;
  assign count_o     = cnt_q;

endmodule

`default_nettype wire

/* rtl/moving_interquartile_mean.sv */
// Moving interquartile mean of the last WINDOW samples (divider width NUM_W
// = 48 at WINDOW 16); one item at a time.
// The single read port of the sorted memory scans remove, insert and sum one
// entry per cycle, and the divider yields one quotient bit per cycle.
// Reset empties the window and zeroes the held mean; memories are not cleared.
// A finished result waits in an output register while the next item is taken.
`default_nettype none

module moving_interquartile_mean #(
  parameter int unsigned WINDOW = miqm_pkg::MIQM_WINDOW
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  miqm_in_if.sink      in_i,
  miqm_out_if.source   out_o
);

  import miqm_pkg::*;

  localparam int unsigned CNT_W = $clog2(WINDOW + 1);
  localparam int unsigned NUM_W = SAMPLE_W + CNT_W + 11;

  miqm_req_t               req;
  miqm_sts_t               core_sts;
  logic signed [NUM_W-1:0] core_num;
  logic [CNT_W-1:0]        core_cnt;
  logic                    div_done;
  logic signed [NUM_W-1:0] div_quo;

  logic                     busy_q, busy_d;
  logic                     res_v_q, res_v_d;
  logic signed [MEAN_W-1:0] res_mean_q, res_mean_d;
  logic [CNT_W-1:0]         res_cnt_q, res_cnt_d;
  logic [CNT_W-1:0]         cnt_hold_q, cnt_hold_d;
  logic signed [MEAN_W-1:0] last_mean_q, last_mean_d;
  logic                     out_v_q, out_v_d;
  logic signed [MEAN_W-1:0] out_mean_q, out_mean_d;
  logic [CNT_W-1:0]         out_cnt_q, out_cnt_d;
  logic                     in_acc, res_move;
  logic [CNT_W+COUNT_W-1:0] cnt_ext;

  assign in_i.ready = !busy_q;
  assign in_acc     = in_i.valid && !busy_q;
  assign res_move   = res_v_q && (!out_v_q || out_o.ready);

  assign req.start  = in_acc;
  assign req.clear  = (in_i.command == CMD_CLEAR);
  assign req.sample = in_i.sample_value;

  miqm_core #(
    .WINDOW (WINDOW),
    .CNT_W  (CNT_W),
    .NUM_W  (NUM_W)
  ) u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req),
    .sts_o   (core_sts),
    .num_o   (core_num),
    .count_o (core_cnt)
  );

  miqm_div #(
    .NUM_W (NUM_W),
    .DEN_W (CNT_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (core_sts.done && !core_sts.clear),
    .num_i   (core_num),
    .den_i   (core_cnt),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // Collect the result, hold it, then hand it to the output register
  always_comb begin
    busy_d      = busy_q;
    res_v_d     = res_v_q;
    res_mean_d  = res_mean_q;
    res_cnt_d   = res_cnt_q;
    cnt_hold_d  = cnt_hold_q;
    last_mean_d = last_mean_q;
    out_v_d     = out_v_q;
    out_mean_d  = out_mean_q;
    out_cnt_d   = out_cnt_q;
    if (in_acc) begin
      busy_d = 1'b1;
    end
    if (core_sts.done) begin
      if (core_sts.clear) begin
        res_v_d    = 1'b1;
        res_mean_d = last_mean_q;
        res_cnt_d  = '0;
      end else begin
        cnt_hold_d = core_cnt;
      end
    end
    if (div_done) begin
      res_v_d     = 1'b1;
      res_mean_d  = div_quo[MEAN_W-1:0];
      last_mean_d = div_quo[MEAN_W-1:0];
      res_cnt_d   = cnt_hold_q;
    end
    if (out_v_q && out_o.ready) begin
      out_v_d = 1'b0;
    end
    if (res_move) begin
      out_v_d    = 1'b1;
      out_mean_d = res_mean_q;
      out_cnt_d  = res_cnt_q;
      res_v_d    = 1'b0;
      busy_d     = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      res_v_q     <= 1'b0;
      out_v_q     <= 1'b0;
      last_mean_q <= '0;
    end else begin
      busy_q      <= busy_d;
      res_v_q     <= res_v_d;
      out_v_q     <= out_v_d;
      last_mean_q <= last_mean_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_mean_q <= res_mean_d;
    res_cnt_q  <= res_cnt_d;
    cnt_hold_q <= cnt_hold_d;
    out_mean_q <= out_mean_d;
    out_cnt_q  <= out_cnt_d;
  end

  assign cnt_ext          = (CNT_W+COUNT_W)'(out_cnt_q);
  assign out_o.valid      = out_v_q;
  assign out_o.mean_value = out_mean_q;
  assign out_o.held_count = cnt_ext[COUNT_W-1:0];

  `include "assert_macros.svh"

  `ASSERT_IMPLIES(a_ready_no_pending, in_i.ready, !res_v_q, "item taken with result pending")
  `ASSERT_ALWAYS(a_one_finisher, !(core_sts.done && div_done), "core and divider finish together")
  `ASSERT_ALWAYS(a_count_bound, core_cnt <= CNT_W'(WINDOW), "held count beyond window")
  `ASSERT_IMPLIES(a_div_busy, div_done, busy_q && !res_v_q, "divider result without an item")

endmodule

`default_nettype wire

/* tb/sv/miqm_checker.sv */
// Checker of the moving interquartile mean block: predicts each result from
// the accepted input items and compares it with the output channel.
// Depends on miqm_pkg and the channel interfaces of rtl/miqm_if.sv.
`timescale 1ns / 100ps
`default_nettype none

module miqm_checker
  import miqm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  miqm_in_if          in_ch,
  miqm_out_if         out_ch,
  output int unsigned fail_cnt_o,
  output int unsigned pending_o
);

  typedef struct packed {
    logic signed [MEAN_W-1:0] mean;
    logic [COUNT_W-1:0]       count;
  } mean_result_t;

  // Predictor state: arrival ring, sorted copy, held mean
  logic signed [SAMPLE_W-1:0] ring_q [MIQM_WINDOW];
  logic signed [SAMPLE_W-1:0] sorted_q [$];
  int unsigned                oldest_idx;
  int unsigned                held_n;
  logic signed [MEAN_W-1:0]   held_mean;
  mean_result_t               expected_means [$];
  int unsigned                fail_cnt;

  assign fail_cnt_o = fail_cnt;
  assign pending_o  = expected_means.size();

  // Interquartile mean of the sorted copy, 8 fraction bits, truncated toward zero
  function automatic logic signed [MEAN_W-1:0] iq_mean();
    int unsigned        n;
    int unsigned        q;
    int unsigned        r;
    longint signed      acc;
    longint signed      ends;
    n   = sorted_q.size();
    acc = 0;
    if (n == 0) return held_mean;
    if (n <= 4) begin
      foreach (sorted_q[k]) acc += longint'(sorted_q[k]);
      return (acc * 256) / longint'(n);
    end
    q = n / 4;
    r = n % 4;
    if (r == 0) begin
      for (int unsigned k = q; k < n - q; k++) acc += longint'(sorted_q[k]);
      return (acc * 512) / longint'(n);
    end
    ends = longint'(sorted_q[q]) + longint'(sorted_q[n-1-q]);
    for (int unsigned k = q + 1; k < n - 1 - q; k++) acc += longint'(sorted_q[k]);
    acc = longint'(4 - r) * ends + 4 * acc;
    return (acc * 128) / longint'(n);
  endfunction

  // Advance the predictor by one accepted item
  task automatic predict_item(logic cmd, logic signed [SAMPLE_W-1:0] smp);
    int unsigned  pos;
    mean_result_t res;
    if (cmd == CMD_CLEAR) begin
      sorted_q.delete();
      held_n     = 0;
      oldest_idx = 0;
    end else begin
      if (held_n >= MIQM_WINDOW) begin
        // drop the first equal entry of the oldest sample
        pos = 0;
        while (pos < sorted_q.size() && sorted_q[pos] < ring_q[oldest_idx]) pos++;
        if (pos < sorted_q.size()) sorted_q.delete(pos);
        ring_q[oldest_idx] = smp;
        oldest_idx = (oldest_idx + 1) % MIQM_WINDOW;
      end else begin
        ring_q[(oldest_idx + held_n) % MIQM_WINDOW] = smp;
        held_n++;
      end
      // place the new sample before equal entries
      pos = 0;
      while (pos < sorted_q.size() && sorted_q[pos] < smp) pos++;
      sorted_q.insert(pos, smp);
      held_mean = iq_mean();
    end
    res.mean  = held_mean;
    res.count = COUNT_W'(held_n);
    expected_means.push_back(res);
  endtask

  // Watch both channels and compare results in order
  always @(posedge clk_i or negedge rst_ni) begin
    mean_result_t want;
    if (!rst_ni) begin
      sorted_q.delete();
      expected_means.delete();
      held_n     <= 0;
      oldest_idx <= 0;
      held_mean  <= '0;
      fail_cnt   <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_means.size() == 0) begin
          if (fail_cnt < 10)
            $display("%0t: unexpected result mean=%0d count=%0d", $realtime,
                     out_ch.mean_value, out_ch.held_count);
          fail_cnt <= fail_cnt + 1;
        end else begin
          want = expected_means.pop_front();
          if (want.mean !== out_ch.mean_value || want.count !== out_ch.held_count) begin
            if (fail_cnt < 10)
              $display("%0t: mismatch mean exp=%0d act=%0d count exp=%0d act=%0d",
                       $realtime, want.mean, out_ch.mean_value, want.count,
                       out_ch.held_count);
            fail_cnt <= fail_cnt + 1;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) predict_item(in_ch.command, in_ch.sample_value);
    end
  end

endmodule

`default_nettype wire

/* tb/sv/moving_interquartile_mean_tb.sv */
// Testbench top of the moving interquartile mean block: clock, reset,
// stimulus with bursty sender and stalling receiver, and the verdict.
// Depends on miqm_pkg, miqm_if, the block and miqm_checker.
`timescale 1ns / 100ps
`default_nettype none

module moving_interquartile_mean_tb;
  import miqm_pkg::*;

  localparam int unsigned NUM_RANDOM = 1630;

  logic        clk_i;
  logic        rst_ni;
  int unsigned fail_cnt;
  int unsigned pending;
  int unsigned burst_left;
  int unsigned long_hold;
  logic        hold_active;

  miqm_in_if  in_ch ();
  miqm_out_if out_ch ();

  moving_interquartile_mean u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch.sink),
    .out_o  (out_ch.source)
  );

  miqm_checker u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .fail_cnt_o (fail_cnt),
    .pending_o  (pending)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Sample pattern: extremes, small values, or full random
  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      2, 3:    return $signed(32'($urandom_range(0, 20))) - 10;
      default: return $signed($urandom());
    endcase
  endfunction

  // Offer one item and hold it until accepted; sender sometimes idles between bursts
  task automatic send_item(logic cmd, logic signed [SAMPLE_W-1:0] smp);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 60) : 0;
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 30);
    end
    in_ch.valid        <= 1'b1;
    in_ch.command      <= cmd;
    in_ch.sample_value <= smp;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    burst_left--;
  endtask

  // Receiver: random stall pattern, plus one long hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else if (hold_active) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) < 70);
    end
  end

  // Count the long hold-off in its own process
  initial begin
    hold_active = 1'b0;
    wait (rst_ni);
    repeat (3000) @(posedge clk_i);
    hold_active = 1'b1;
    for (long_hold = 0; long_hold < 2000; long_hold++) @(posedge clk_i);
    hold_active = 1'b0;
  end

  // Run limit
  initial begin
    #60ms;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    logic signed [SAMPLE_W-1:0] dir_vals [$];
    in_ch.valid        <= 1'b0;
    in_ch.command      <= CMD_INSERT;
    in_ch.sample_value <= '0;
    burst_left = 0;
    rst_ni = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: clear before any insert, extremes, equal samples, full window
    send_item(CMD_CLEAR, 32'sh7fff_ffff);
    dir_vals = '{32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh8000_0000, -1, 0, 1,
                 32'sh8000_0000, 5, 5, 5, -7, 3, 32'sh7fff_ffff, 2, 9, -3, 4, 100,
                 -100, 32'sh8000_0000};
    foreach (dir_vals[k]) send_item(CMD_INSERT, dir_vals[k]);
    send_item(CMD_CLEAR, 0);
    send_item(CMD_CLEAR, 0);
    send_item(CMD_INSERT, -5);

    // Random: mostly inserts, clears now and then at random fill levels
    for (int unsigned k = 0; k < NUM_RANDOM; k++) begin
      if ($urandom_range(0, 29) == 0) send_item(CMD_CLEAR, $signed($urandom()));
      else send_item(CMD_INSERT, pick_sample());
    end
    in_ch.valid <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* files.f */
+incdir+rtl
rtl/miqm_pkg.sv
rtl/miqm_if.sv
rtl/miqm_div.sv
rtl/miqm_core.sv
rtl/moving_interquartile_mean.sv
tb/sv/miqm_checker.sv
tb/sv/moving_interquartile_mean_tb.sv
